// File: hw/rtl/efc_pkg.sv
package efc_pkg;

  // queue between the byte front end and the result back end
  localparam int QueueDepth = 4;
  localparam int QueuePtrBits = $clog2(QueueDepth);

  localparam logic [31:0] CrcPoly = 32'hEDB88320;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_MIN_PAYLOAD = 3'd0,
    CFG_MAX_PAYLOAD = 3'd1,
    CFG_ETYPE_FLOOR = 3'd2,
    CFG_PREAMBLE    = 3'd3,
    CFG_SFD         = 3'd4,
    CFG_BIG_ENDIAN  = 3'd5
  } efc_cfg_idx_e;

  // frame status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_BAD_PREAMB  = 3'd2,
    ST_LEN_MISMATCH = 3'd3,
    ST_BAD_TYPE    = 3'd4,
    ST_TYPED_SHORT = 3'd5,
    ST_TOO_LONG    = 3'd6,
    ST_CRC_BAD     = 3'd7
  } efc_status_e;

  // result kinds
  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } efc_kind_e;

  typedef struct packed {
    logic [7:0]  min_len;
    logic [13:0] max_len;
    logic [15:0] etype_floor;
    logic [7:0]  preamble;
    logic [7:0]  sfd;
    logic        big_endian;
  } efc_cfg_t;

  // one queue entry: an optional payload byte and an optional frame end
  typedef struct packed {
    logic        pay_vld;
    logic [7:0]  pay_byte;
    logic        pay_pad;
    logic        eof;
    logic        pre_good;
    logic [15:0] cnt;
    logic [15:0] tl;
    logic [31:0] crc;
    logic [31:0] fcs;
    logic [47:0] dest;
    logic [47:0] src;
  } efc_cmd_t;

  typedef struct packed {
    efc_kind_e   kind;
    logic [7:0]  payload_byte;
    logic        is_padding;
    efc_status_e status;
    logic        format;
    logic [15:0] type_len;
    logic [15:0] client_length;
    logic [15:0] padded_length;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
  } efc_res_t;

  // type/length field in the configured byte order; raw holds the first byte high
  function automatic logic [15:0] type_order(input logic [15:0] raw, input logic big);
    type_order = big ? raw : {raw[7:0], raw[15:8]};
  endfunction

endpackage

// File: hw/rtl/efc_queue.sv
module efc_queue
  import efc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  efc_cmd_t cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output efc_cmd_t cmd_o
);

  efc_cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrBits-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueuePtrBits-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QueuePtrBits:0]    count_q, count_d;
  logic                     do_push, do_pop;

  assign full_o  = (count_q == (QueuePtrBits + 1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: hw/rtl/efc_front.sv
module efc_front
  import efc_pkg::*;
#(
  parameter int PREAMBLE_BYTES = 7,
  parameter int COUNT_BITS     = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  efc_cfg_t   cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       end_of_frame_i,
  input  logic       full_i,
  output logic       push_o,
  output efc_cmd_t   cmd_o
);

  localparam int HdrLen = PREAMBLE_BYTES + 15;
  localparam logic [COUNT_BITS-1:0] PosSfd     = COUNT_BITS'(PREAMBLE_BYTES);
  localparam logic [COUNT_BITS-1:0] PosSrc     = COUNT_BITS'(PREAMBLE_BYTES + 7);
  localparam logic [COUNT_BITS-1:0] PosDstLast = COUNT_BITS'(PREAMBLE_BYTES + 6);
  localparam logic [COUNT_BITS-1:0] PosSrcLast = COUNT_BITS'(PREAMBLE_BYTES + 12);
  localparam logic [COUNT_BITS-1:0] PosTypeHi  = COUNT_BITS'(PREAMBLE_BYTES + 13);
  localparam logic [COUNT_BITS-1:0] PosPay     = COUNT_BITS'(HdrLen);
  localparam logic [COUNT_BITS-1:0] PosOut     = COUNT_BITS'(HdrLen + 4);
  localparam logic [COUNT_BITS-1:0] CntMax     = '1;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    crc_byte = r;
  endfunction

  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_upd;
  logic                  pre_good_q, pre_good_d, pre_good_upd;
  logic [31:0]           crc_q, crc_d, crc_upd;
  logic [7:0]            dl_q [4];
  logic [7:0]            dl_d [4];
  logic [7:0]            dl_upd [4];
  logic [47:0]           dest_q, dest_d, dest_upd;
  logic [47:0]           src_q, src_d, src_upd;
  logic [15:0]           tl_q, tl_d, tl_upd;

  logic                  accept;
  logic                  in_pre, is_sfd, in_dst, in_src, in_type, out_pay;
  logic [2:0]            dst_lane, src_lane;
  logic                  feed;
  logic [7:0]            feed_byte;
  logic [COUNT_BITS-1:0] idx;
  logic [15:0]           tl_now;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;

  // classify the byte by its position in the frame
  always_comb begin
    in_pre   = cnt_q < PosSfd;
    is_sfd   = cnt_q == PosSfd;
    in_dst   = (cnt_q > PosSfd) && (cnt_q < PosSrc);
    in_src   = (cnt_q >= PosSrc) && (cnt_q < PosTypeHi);
    in_type  = (cnt_q >= PosTypeHi) && (cnt_q < PosPay);
    out_pay  = cnt_q >= PosOut;
    dst_lane = 3'(PosDstLast - cnt_q);
    src_lane = 3'(PosSrcLast - cnt_q);
    idx      = cnt_q - PosOut;
    tl_now   = type_order(tl_q, cfg_i.big_endian);
  end

  // per-byte state update
  always_comb begin
    pre_good_upd = pre_good_q;
    dest_upd     = dest_q;
    src_upd      = src_q;
    tl_upd       = tl_q;
    dl_upd       = dl_q;
    feed         = 1'b0;
    feed_byte    = rx_byte_i;

    if (in_pre) begin
      if (rx_byte_i != cfg_i.preamble) pre_good_upd = 1'b0;
    end else if (is_sfd) begin
      if (rx_byte_i != cfg_i.sfd) pre_good_upd = 1'b0;
    end else if (in_dst) begin
      feed = 1'b1;
      for (int i = 0; i < 6; i++) begin
        if (dst_lane == 3'(i)) dest_upd[i*8 +: 8] = rx_byte_i;
      end
    end else if (in_src) begin
      feed = 1'b1;
      for (int i = 0; i < 6; i++) begin
        if (src_lane == 3'(i)) src_upd[i*8 +: 8] = rx_byte_i;
      end
    end else if (in_type) begin
      feed = 1'b1;
      if (cnt_q == PosTypeHi) begin
        tl_upd[15:8] = rx_byte_i;
      end else begin
        tl_upd[7:0] = rx_byte_i;
      end
    end else begin
      feed      = out_pay;
      feed_byte = dl_q[3];
      dl_upd[3] = dl_q[2];
      dl_upd[2] = dl_q[1];
      dl_upd[1] = dl_q[0];
      dl_upd[0] = rx_byte_i;
    end

    crc_upd = feed ? crc_byte(crc_q, feed_byte) : crc_q;
    cnt_upd = (cnt_q == CntMax) ? cnt_q : cnt_q + 1'b1;
  end

  // request to the back end
  always_comb begin
    cmd_o.pay_vld  = out_pay;
    cmd_o.pay_byte = dl_q[3];
    cmd_o.pay_pad  = (tl_now <= {2'b00, cfg_i.max_len}) && (16'(idx) >= tl_now);
    cmd_o.eof      = end_of_frame_i;
    cmd_o.pre_good = pre_good_upd;
    cmd_o.cnt      = 16'(cnt_upd);
    cmd_o.tl       = type_order(tl_upd, cfg_i.big_endian);
    cmd_o.crc      = crc_upd;
    cmd_o.fcs      = {dl_upd[0], dl_upd[1], dl_upd[2], dl_upd[3]};
    cmd_o.dest     = dest_upd;
    cmd_o.src      = src_upd;
    push_o         = accept & (out_pay | end_of_frame_i);
  end

  // next state, cleared at frame end
  always_comb begin
    cnt_d      = cnt_q;
    pre_good_d = pre_good_q;
    crc_d      = crc_q;
    dl_d       = dl_q;
    dest_d     = dest_q;
    src_d      = src_q;
    tl_d       = tl_q;
    if (accept) begin
      if (end_of_frame_i) begin
        cnt_d      = '0;
        pre_good_d = 1'b1;
        crc_d      = '1;
        for (int i = 0; i < 4; i++) dl_d[i] = '0;
        dest_d     = '0;
        src_d      = '0;
        tl_d       = '0;
      end else begin
        cnt_d      = cnt_upd;
        pre_good_d = pre_good_upd;
        crc_d      = crc_upd;
        dl_d       = dl_upd;
        dest_d     = dest_upd;
        src_d      = src_upd;
        tl_d       = tl_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      pre_good_q <= 1'b1;
      crc_q      <= '1;
      for (int i = 0; i < 4; i++) dl_q[i] <= '0;
      dest_q     <= '0;
      src_q      <= '0;
      tl_q       <= '0;
    end else begin
      cnt_q      <= cnt_d;
      pre_good_q <= pre_good_d;
      crc_q      <= crc_d;
      dl_q       <= dl_d;
      dest_q     <= dest_d;
      src_q      <= src_d;
      tl_q       <= tl_d;
    end
  end

endmodule

// File: hw/rtl/efc_back.sv
module efc_back
  import efc_pkg::*;
#(
  parameter int PREAMBLE_BYTES = 7
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  efc_cfg_t cfg_i,
  input  logic     q_valid_i,
  input  efc_cmd_t q_cmd_i,
  output logic     q_pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output efc_res_t res_o
);

  localparam int HdrLen = PREAMBLE_BYTES + 15;
  localparam logic [17:0] MinCnt = 18'(HdrLen + 4);

  logic        phase_q, phase_d;
  logic        vld_q, vld_d;
  efc_res_t    res_q, res_d;
  logic        load;

  logic [17:0] cnt;
  logic [17:0] tl;
  logic [17:0] min_len;
  logic [17:0] max_len;
  logic [17:0] padded;
  logic [17:0] client;
  logic        is_len;
  logic        fmt;
  efc_status_e status;
  efc_res_t    pay_res, st_res;

  // frame checks in priority order
  always_comb begin
    cnt     = 18'(q_cmd_i.cnt);
    tl      = 18'(q_cmd_i.tl);
    min_len = 18'(cfg_i.min_len);
    max_len = 18'(cfg_i.max_len);
    is_len  = tl <= max_len;
    if (is_len) begin
      padded = (tl < min_len) ? min_len : tl;
      client = tl;
    end else begin
      padded = (cnt >= MinCnt) ? cnt - MinCnt : '0;
      client = padded;
    end
    fmt = !is_len && (q_cmd_i.tl >= cfg_i.etype_floor);

    status = ST_OK;
    if (cnt < MinCnt) begin
      status = ST_SHORT;
    end else if (!q_cmd_i.pre_good) begin
      status = ST_BAD_PREAMB;
    end else if (is_len) begin
      if (cnt != MinCnt + padded) status = ST_LEN_MISMATCH;
    end else if (q_cmd_i.tl < cfg_i.etype_floor) begin
      status = ST_BAD_TYPE;
    end else if (cnt < MinCnt + min_len) begin
      status = ST_TYPED_SHORT;
    end else if (padded > max_len) begin
      status = ST_TOO_LONG;
    end
    if (status == ST_OK && ~q_cmd_i.crc != q_cmd_i.fcs) status = ST_CRC_BAD;
  end

  // the two result shapes
  always_comb begin
    pay_res              = '0;
    pay_res.kind         = KIND_PAYLOAD;
    pay_res.payload_byte = q_cmd_i.pay_byte;
    pay_res.is_padding   = q_cmd_i.pay_pad;

    st_res               = '0;
    st_res.kind          = KIND_STATUS;
    st_res.status        = status;
    st_res.format        = fmt;
    st_res.type_len      = q_cmd_i.tl;
    st_res.client_length = 16'(client);
    st_res.padded_length = 16'(padded);
    st_res.dest_mac      = q_cmd_i.dest;
    st_res.source_mac    = q_cmd_i.src;
  end

  // output slot: payload first, then status of the same request
  always_comb begin
    load    = !vld_q || !out_stall_i;
    q_pop_o = 1'b0;
    phase_d = phase_q;
    vld_d   = vld_q;
    res_d   = res_q;
    if (load) begin
      vld_d = 1'b0;
      if (q_valid_i) begin
        vld_d = 1'b1;
        if (q_cmd_i.pay_vld && !phase_q) begin
          res_d = pay_res;
          if (q_cmd_i.eof) begin
            phase_d = 1'b1;
          end else begin
            q_pop_o = 1'b1;
          end
        end else begin
          res_d   = st_res;
          q_pop_o = 1'b1;
          phase_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

// File: hw/rtl/ethernet_rx_frame_checker.sv
// An input byte's request enters the queue on the accepting edge; the output register then
// loads the result from the queue head when the output slot is free (not stalled).
// Throughput: one byte per cycle while the queue is not full; a final byte that also releases
// a payload byte yields two results, payload then status, absorbed by a four-entry queue.
// Stall on the input side follows the queue being full.
// Reset clears all frame state, empties the queue and loads the register defaults.
module ethernet_rx_frame_checker
  import efc_pkg::*;
#(
  parameter int PREAMBLE_BYTES = 7,
  parameter int COUNT_BITS     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        end_of_frame_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        is_padding_o,
  output logic [2:0]  frame_status_o,
  output logic        frame_format_o,
  output logic [15:0] type_len_o,
  output logic [15:0] client_length_o,
  output logic [15:0] padded_length_o,
  output logic [47:0] dest_mac_o,
  output logic [47:0] source_mac_o
);

  efc_cfg_t cfg_q, cfg_d;
  logic     push, full, pop, q_valid;
  efc_cmd_t push_cmd, head_cmd;
  efc_res_t res;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (efc_cfg_idx_e'(cfg_index_i))
        CFG_MIN_PAYLOAD: cfg_d.min_len     = cfg_data_i[7:0];
        CFG_MAX_PAYLOAD: cfg_d.max_len     = cfg_data_i[13:0];
        CFG_ETYPE_FLOOR: cfg_d.etype_floor = cfg_data_i;
        CFG_PREAMBLE:    cfg_d.preamble    = cfg_data_i[7:0];
        CFG_SFD:         cfg_d.sfd         = cfg_data_i[7:0];
        CFG_BIG_ENDIAN:  cfg_d.big_endian  = cfg_data_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_len     <= 8'd46;
      cfg_q.max_len     <= 14'd1500;
      cfg_q.etype_floor <= 16'd1536;
      cfg_q.preamble    <= 8'h55;
      cfg_q.sfd         <= 8'hD5;
      cfg_q.big_endian  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  efc_front #(
    .PREAMBLE_BYTES(PREAMBLE_BYTES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .end_of_frame_i(end_of_frame_i),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  efc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .cmd_o  (head_cmd)
  );

  efc_back #(
    .PREAMBLE_BYTES(PREAMBLE_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_cmd_i    (head_cmd),
    .q_pop_o    (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res)
  );

  // result fields
  assign item_kind_o     = res.kind;
  assign payload_byte_o  = res.payload_byte;
  assign is_padding_o    = res.is_padding;
  assign frame_status_o  = res.status;
  assign frame_format_o  = res.format;
  assign type_len_o      = res.type_len;
  assign client_length_o = res.client_length;
  assign padded_length_o = res.padded_length;
  assign dest_mac_o      = res.dest_mac;
  assign source_mac_o    = res.source_mac;

endmodule
